// File: hw/rtl/werol_pkg.sv
// shared types, sizes and helpers of the write entry ring offset lookup unit
`timescale 1ns / 1ps

package werol_pkg;

    // ring geometry
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // field widths
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFS_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int ENTRY_W  = HANDLE_W + SIZE_W;
    localparam int SUM_W    = SIZE_W + CNT_W;
    localparam int CMP_W    = OFFS_W + 1;

    // stream widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 104;

    // item kinds
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_FIND
    } t_state;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [SIZE_W-1:0]   evicted_size;
        logic [HANDLE_W-1:0] evicted_handle;
        logic                evicted;
        logic [SIZE_W-1:0]   byte_in_entry;
        logic [HANDLE_W-1:0] found_handle;
        logic [SLOT_W-1:0]   found_slot;
        logic                found;
    } t_result;

    // slot memory access from the sequencer
    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } t_mem_req;

    // ring position step with wrap at the last slot
    function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/werol_ram.sv
// single write port, single registered read port slot memory
`timescale 1ns / 1ps

module werol_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/werol_ctrl.sv
// sequencer: ring pointers, add read-modify-write and the find walk
`timescale 1ns / 1ps

module werol_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic [werol_pkg::HANDLE_W-1:0] i_handle,
    input  logic [werol_pkg::SIZE_W-1:0]   i_size,
    input  logic [werol_pkg::OFFS_W-1:0]   i_offset,
    output werol_pkg::t_mem_req          o_mem,
    input  logic [werol_pkg::ENTRY_W-1:0]  i_rd_data,
    output logic                         o_res_valid,
    output werol_pkg::t_result           o_res,
    input  logic                         i_res_ready
);

    import werol_pkg::*;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]   r_wp, n_wp;
    logic [ADDR_W-1:0]   r_rp, n_rp;
    logic                r_full, n_full;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [HANDLE_W-1:0] r_handle;
    logic [SIZE_W-1:0]   r_size;
    logic [OFFS_W-1:0]   r_offset;

    logic [HANDLE_W-1:0] w_rd_handle;
    logic [SIZE_W-1:0]   w_rd_size;
    logic [CMP_W-1:0]    w_sum_ext;
    logic                w_walk_end;
    logic                w_no_entry;
    logic                w_hit;
    logic                w_accept;

    assign w_rd_handle = i_rd_data[ENTRY_W-1:SIZE_W];
    assign w_rd_size   = i_rd_data[SIZE_W-1:0];
    assign w_sum_ext   = CMP_W'(r_sum) + CMP_W'(w_rd_size);
    assign w_walk_end  = (r_cnt == CNT_W'(DEPTH)) || (!r_full && (r_idx == r_wp));
    assign w_no_entry  = w_walk_end || (w_rd_handle == '0);
    assign w_hit       = !w_no_entry && (CMP_W'(r_offset) < w_sum_ext);
    assign w_accept    = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_action == ACT_ADD) ? ST_ADD : ST_FIND;
                end
            end
            ST_ADD: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIND: begin
                if ((w_no_entry || w_hit) && i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready    = 1'b0;
        o_mem         = '0;
        o_res_valid   = 1'b0;
        o_res         = '0;
        n_wp          = r_wp;
        n_rp          = r_rp;
        n_full        = r_full;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_sum         = r_sum;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_mem.rd_en   = i_in_valid;
                o_mem.rd_addr = (i_action == ACT_ADD) ? r_wp : r_rp;
                n_idx         = r_rp;
                n_cnt         = '0;
                n_sum         = '0;
            end
            ST_ADD: begin
                o_res_valid = 1'b1;
                if (r_full) begin
                    o_res.evicted        = 1'b1;
                    o_res.evicted_handle = w_rd_handle;
                    o_res.evicted_size   = w_rd_size;
                end
                if (i_res_ready) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_wp;
                    o_mem.wr_data = {r_handle, r_size};
                    n_wp          = next_pos(r_wp);
                    if (r_full) begin
                        n_rp = next_pos(r_rp);
                    end
                    if (next_pos(r_wp) == (r_full ? next_pos(r_rp) : r_rp)) begin
                        n_full = 1'b1;
                    end
                end
            end
            ST_FIND: begin
                if (w_no_entry || w_hit) begin
                    o_res_valid = 1'b1;
                    if (w_hit) begin
                        o_res.found         = 1'b1;
                        o_res.found_slot    = SLOT_W'(r_idx);
                        o_res.found_handle  = w_rd_handle;
                        o_res.byte_in_entry = SIZE_W'(r_offset - OFFS_W'(r_sum));
                    end
                end else begin
                    // fetch the next slot while this one is added up
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = next_pos(r_idx);
                    n_idx         = next_pos(r_idx);
                    n_cnt         = r_cnt + CNT_W'(1);
                    n_sum         = SUM_W'(w_sum_ext);
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_full  <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_full  <= n_full;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_handle <= i_handle;
            r_size   <= i_size;
            r_offset <= i_offset;
        end
    end

`ifndef ASSERT_OFF
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wp == r_rp))
        else $error("ring full but write and read positions differ");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIND) |-> (r_cnt <= CNT_W'(DEPTH)))
        else $error("find walk passed the ring depth");

    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> (o_res_valid && i_res_ready && (r_state == ST_ADD)))
        else $error("slot written without an add result being passed on");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted item did not start work");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem.wr_en && o_mem.rd_en))
        else $error("slot read and write in the same cycle");
`endif

endmodule

// File: hw/rtl/write_entry_ring_offset_lookup_unit.sv
// top level of the write entry ring offset lookup unit
`timescale 1ns / 1ps

// ring of DEPTH slots (handle and byte size) with overwrite of the oldest slot
// input stream s_axis: tuser carries the action (add or find), tdata the entry
//   handle, entry byte count and lookup offset; one result transfer per input
// output stream m_axis: tdata carries the find fields and the eviction fields,
//   the fields of the other action read as zero
// an add reads the slot at the write position in its input transfer cycle; in
//   the add state it passes its result to the output register and writes the
//   slot in the same cycle, then returns to idle for the next input transfer
// a find walks the slots from the read position, adding up their byte sizes,
//   until the offset falls in a slot or the walk ends (write position reached,
//   all DEPTH slots summed or an empty handle), then passes its result to the
//   output register; the walk reads one slot a cycle from the single read port
//   of the slot memory, which sets the rate
// items are worked one at a time; s_axis_tready is high whenever the sequencer
//   is idle, even while a result still waits in the output register
// a stalled m_axis holds the finished result in the sequencer, nothing is lost
// reset clears the ring positions and the full flag; slot contents are left
//   as they are and a slot not yet written never reaches a result

module write_entry_ring_offset_lookup_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_handle[31:0], entry_bytes[47:32], lookup_offset[79:48]
    input  logic [werol_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found[0], found_slot[6:1], found_handle[38:7], byte_in_entry[54:39],
    // evicted[55], evicted_handle[87:56], evicted_size[103:88]
    output logic [werol_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import werol_pkg::*;

    t_mem_req            w_mem;
    logic [ENTRY_W-1:0]  w_rd_data;
    logic                w_res_valid;
    logic                w_res_ready;
    t_result             w_res;

    logic                r_m_valid;
    t_result             r_m_data;

    // result register frees up when empty or being taken this cycle
    assign w_res_ready = !r_m_valid || m_axis_tready;

    werol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_handle    (s_axis_tdata[31:0]),
        .i_size      (s_axis_tdata[47:32]),
        .i_offset    (s_axis_tdata[79:48]),
        .o_mem       (w_mem),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // slot store: handle in the upper bits, size in the lower bits
    werol_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mem.wr_en),
        .i_wr_addr (w_mem.wr_addr),
        .i_wr_data (w_mem.wr_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_data <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_m_data);

endmodule
